### rtl/core/assert_macros.svh
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and held off during reset.
`define MHKV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mhkv assertion failed");

// Next-cycle implication, sampled on the rising clock edge and held off during reset.
`define MHKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mhkv assertion failed");

`endif

### rtl/core/mhkv_pkg.sv
package mhkv_pkg;

    // Field widths of the words on the two channels and the register.
    localparam int KEY_W = 32;
    localparam int VAL_W = 64;
    localparam int CNT_W = 9;
    localparam int CFG_W = 7;
    localparam int OP_W  = 2;
    localparam int STS_W = 2;

    // One stored entry is a key followed by its value.
    localparam int ENT_W = KEY_W + VAL_W;

    // Step counter of the bit-serial modulo unit.
    localparam int STEP_W = $clog2(KEY_W);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd1;
    localparam logic [OP_W-1:0] OP_GET    = 2'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

    // Status codes.
    localparam logic [STS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL = 2'd2;

    // Input word.
    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [VAL_W-1:0] found_value;
        logic [CNT_W-1:0] entry_count;
    } out_word_t;

    // Result of the modulo unit.
    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] rem;
    } mhkv_div_res_t;

    // Outcome of one bucket update.
    typedef struct packed {
        logic             wr;
        logic             inc;
        logic             dec;
        logic [STS_W-1:0] status;
        logic [VAL_W-1:0] found;
    } mhkv_upd_t;

endpackage

### rtl/core/mhkv_ram.sv
module mhkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port; the read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/mhkv_div.sv
module mhkv_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mhkv_pkg::KEY_W-1:0]    key,
    input  logic [mhkv_pkg::CFG_W-1:0]    divisor,
    output mhkv_pkg::mhkv_div_res_t       res
);

    import mhkv_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [CFG_W-1:0]  div_reg;
    logic [CFG_W-1:0]  rem_reg;
    logic [CFG_W:0]    trial;
    logic [CFG_W-1:0]  rem_next;

    // One restoring step: bring in the next key bit and subtract the divisor if it fits.
    always_comb
    begin
        trial = {rem_reg, key_reg[KEY_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = CFG_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[CFG_W-1:0];
        end
    end

    // Control of the step sequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(KEY_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: shifting key and running remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= key;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            key_reg <= key_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign res.done = done_reg;
    assign res.rem  = rem_reg;

endmodule

### rtl/core/mhkv_bucket.sv
module mhkv_bucket #(
    parameter int WAYS = 4
) (
    input  logic [mhkv_pkg::OP_W-1:0]                  opcode,
    input  logic [mhkv_pkg::KEY_W-1:0]                 key,
    input  logic [mhkv_pkg::VAL_W-1:0]                 value,
    input  logic [WAYS*(mhkv_pkg::ENT_W+1)-1:0]        row,
    output logic [WAYS*(mhkv_pkg::ENT_W+1)-1:0]        row_new,
    output mhkv_pkg::mhkv_upd_t                        upd
);

    import mhkv_pkg::*;

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int VLD_LSB = WAYS * ENT_W;

    logic [WAYS-1:0]  vld;
    logic [WAYS-1:0]  match;
    logic             hit;
    logic [WAY_W-1:0] hit_idx;
    logic             free;
    logic [WAY_W-1:0] free_idx;
    logic [VAL_W-1:0] hit_value;

    // Compare every way of the bucket; the lowest matching and lowest free way win.
    always_comb
    begin
        vld       = row[VLD_LSB +: WAYS];
        hit       = 1'b0;
        hit_idx   = '0;
        free      = 1'b0;
        free_idx  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = vld[w] && (row[w*ENT_W + VAL_W +: KEY_W] == key);
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit     = 1'b1;
                hit_idx = WAY_W'(w);
            end
            if (!vld[w])
            begin
                free     = 1'b1;
                free_idx = WAY_W'(w);
            end
        end
        hit_value = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (hit_idx == WAY_W'(w))
            begin
                hit_value = row[w*ENT_W +: VAL_W];
            end
        end
    end

    // Apply the operation to a copy of the row.
    always_comb
    begin
        row_new    = row;
        upd.wr     = 1'b0;
        upd.inc    = 1'b0;
        upd.dec    = 1'b0;
        upd.status = ST_OK;
        upd.found  = '0;
        unique case (opcode)
            OP_INSERT:
            begin
                if (hit)
                begin
                    upd.wr = 1'b1;
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (hit_idx == WAY_W'(w))
                        begin
                            row_new[w*ENT_W +: VAL_W] = value;
                        end
                    end
                end
                else if (free)
                begin
                    upd.wr  = 1'b1;
                    upd.inc = 1'b1;
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (free_idx == WAY_W'(w))
                        begin
                            row_new[w*ENT_W +: ENT_W] = {key, value};
                            row_new[VLD_LSB + w]      = 1'b1;
                        end
                    end
                end
                else
                begin
                    upd.status = ST_FULL;
                end
            end
            OP_MODIFY:
            begin
                if (hit)
                begin
                    upd.wr = 1'b1;
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (hit_idx == WAY_W'(w))
                        begin
                            row_new[w*ENT_W +: VAL_W] = value;
                        end
                    end
                end
                else
                begin
                    upd.status = ST_MISS;
                end
            end
            OP_GET:
            begin
                if (hit)
                begin
                    upd.found = hit_value;
                end
                else
                begin
                    upd.status = ST_MISS;
                end
            end
            OP_DELETE:
            begin
                if (hit)
                begin
                    upd.wr    = 1'b1;
                    upd.dec   = 1'b1;
                    upd.found = hit_value;
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (hit_idx == WAY_W'(w))
                        begin
                            row_new[VLD_LSB + w] = 1'b0;
                        end
                    end
                end
                else
                begin
                    upd.status = ST_MISS;
                end
            end
            default:
            begin
                upd.status = ST_MISS;
            end
        endcase
    end

endmodule

### rtl/core/modulo_hash_key_value_table_top.sv
// Key-value table with buckets chosen by key modulo the bucket count.
// Input channel: in_valid/in_stall carry one operation word (opcode, key, value).
// Output channel: out_valid/out_stall carry one result word (status, found value,
// entry count) for every accepted input word, in order.
// Configuration: cfg_we writes cfg_data into the bucket count register; write it only
// while no operation is in flight.
// Sequence: the 32-step bit-serial key modulo runs first; the bucket row is then read
// from the RAM, held in S_READ, and in S_MODIFY the ways are compared, the row is
// written back and the result is loaded.
// One operation is in flight at a time, and a new word is taken on the edge after the
// previous result enters the output register.
// Reset: a clearing pass writes every bucket row empty, one row per cycle; in_stall stays
// high until it ends. The bucket count returns to BUCKETS, capped at 127.
// Receiver stall: a held result stays in the output register; a finished operation
// waits with its write-back until that register is free.
module modulo_hash_key_value_table_top #(
    parameter int BUCKETS = 64,
    parameter int WAYS    = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  mhkv_pkg::in_word_t              in_word,
    output logic                            out_valid,
    input  logic                            out_stall,
    output mhkv_pkg::out_word_t             out_word,
    input  logic                            cfg_we,
    input  logic [mhkv_pkg::CFG_W-1:0]      cfg_data
);

    import mhkv_pkg::*;

    localparam int ADDR_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int ROW_W   = WAYS * (ENT_W + 1);
    localparam int HELD_W  = $clog2(BUCKETS * WAYS + 1);
    localparam int CFG_RST = (BUCKETS > 127) ? 127 : BUCKETS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVIDE,
        S_READ,
        S_MODIFY
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] clr_idx_reg;
    logic [CFG_W-1:0]  cfg_reg;
    logic [HELD_W-1:0] held_reg;
    logic [HELD_W-1:0] held_next;
    in_word_t          op_reg;
    logic              out_valid_reg;
    out_word_t         out_word_reg;

    logic              accept;
    logic              out_free;
    logic [CFG_W-1:0]  divisor;
    mhkv_div_res_t     div_res;
    logic [ADDR_W-1:0] bucket;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ROW_W-1:0]  ram_rdata;
    logic [ROW_W-1:0]  row_new;
    mhkv_upd_t         upd;

    // Handshake decode.
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Bucket count in use: zero acts as one, anything above BUCKETS acts as BUCKETS.
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            divisor = CFG_W'(1);
        end
        else if (32'(cfg_reg) > 32'(BUCKETS))
        begin
            divisor = CFG_W'(CFG_RST);
        end
        else
        begin
            divisor = cfg_reg;
        end
    end

    // Bit-serial key modulo.
    mhkv_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .key     (in_word.key),
        .divisor (divisor),
        .res     (div_res)
    );

    // The remainder is below the divisor, which never exceeds BUCKETS.
    assign bucket = ADDR_W'(div_res.rem);

    // Bucket row store: one row per bucket, valid bits and all ways side by side.
    mhkv_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (bucket),
        .rdata (ram_rdata)
    );

    // Way compare and row update.
    mhkv_bucket #(
        .WAYS (WAYS)
    ) u_bucket (
        .opcode  (op_reg.opcode),
        .key     (op_reg.key),
        .value   (op_reg.value),
        .row     (ram_rdata),
        .row_new (row_new),
        .upd     (upd)
    );

    // RAM port control: the clearing pass, then the read and write-back of each operation.
    always_comb
    begin
        ram_re    = (state_reg == S_DIVIDE) && div_res.done;
        ram_we    = 1'b0;
        ram_waddr = bucket;
        ram_wdata = row_new;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = '0;
        end
        else if ((state_reg == S_MODIFY) && out_free)
        begin
            ram_we = upd.wr;
        end
    end

    // Entry count after the current operation.
    always_comb
    begin
        held_next = held_reg;
        if (upd.inc)
        begin
            held_next = held_reg + 1'b1;
        end
        else if (upd.dec && (held_reg != '0))
        begin
            held_next = held_reg - 1'b1;
        end
    end

    // Sequencer, count, register and output word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            cfg_reg       <= CFG_W'(CFG_RST);
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
            // A taken result is dropped unless a new one is loaded on the same edge.
            if (out_valid_reg && !out_stall && (state_reg != S_MODIFY))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == ADDR_W'(BUCKETS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_DIVIDE;
                    end
                end
                S_DIVIDE:
                begin
                    if (div_res.done)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_MODIFY;
                end
                S_MODIFY:
                begin
                    if (out_free)
                    begin
                        held_reg                 <= held_next;
                        out_valid_reg            <= 1'b1;
                        out_word_reg.status      <= upd.status;
                        out_word_reg.found_value <= upd.found;
                        out_word_reg.entry_count <= CNT_W'(held_next);
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Operation word held for the whole operation.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= in_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

### rtl/core/mhkv_checker.sv
`include "assert_macros.svh"

module mhkv_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input mhkv_pkg::out_word_t         out_word
);

    import mhkv_pkg::*;

    logic status_known;

    // The status is one of the three defined codes.
    assign status_known = (out_word.status == ST_OK) || (out_word.status == ST_MISS) ||
                          (out_word.status == ST_FULL);

    // A result word held by the receiver stays in place.
    `MHKV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))

    // Only the three defined status codes appear.
    `MHKV_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, status_known)

    // A miss or a full bucket returns no value.
    `MHKV_ASSERT_IMP(a_found_zero, clk, rst_n, out_valid && (out_word.status != ST_OK), out_word.found_value == '0)

    // Once a word is taken the block is busy with it and takes no other.
    `MHKV_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

bind modulo_hash_key_value_table_top mhkv_checker u_checker (.*);
